@@ rtl/cpb_pkg.sv @@
package cpb_pkg;

    localparam int MAX_COLS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = COL_W + 1;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 1;

    localparam logic             OP_SINGLETON = 1'b0;
    localparam logic             OP_DEAD      = 1'b1;
    localparam logic [IDX_W-1:0] CFG_N_COLS   = 1'd0;
    localparam logic [IDX_W-1:0] CFG_N1_COLS  = 1'd1;

    typedef struct packed {
        logic             operation;
        logic [COL_W-1:0] column;
        logic             dead;
        logic             last;
    } t_in_req;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        logic [COL_W-1:0] position;
        logic [COL_W-1:0] inverse;
        logic             live;
        logic [CNT_W-1:0] rank;
        logic             final_res;
    } t_out_res;

    typedef struct packed {
        logic                clear;
        logic                ord_re;
        logic [COL_W-1:0]    ord_raddr;
    } t_pack_ctl;

    typedef struct packed {
        logic [MAX_COLS-1:0] mapped;
        logic [CNT_W-1:0]    next_pos;
        logic [COL_W-1:0]    ord_rdata;
    } t_load_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_RD,
        S_A_WR,
        S_B,
        S_C_RD,
        S_C_LD,
        S_C_WAIT
    } t_state;

endpackage

@@ rtl/column_permutation_builder_top.sv @@
// Load requests are accepted back to back while the builder is idle. A request
// marked last starts the build: a walk of the order RAM over the mapped columns,
// a sweep over the unmapped columns, then each result is read, loaded and held
// until taken. Input stalls from the last request until the final result is taken.
// Reset is synchronous, active low: clears load state, n_cols to 64, n1_cols to 0.
module column_permutation_builder_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  cpb_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cpb_pkg::t_out_res         o_out_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cpb_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [cpb_pkg::CFG_W-1:0] i_cfg_data
);
    import cpb_pkg::*;

    logic [CNT_W-1:0] r_n_cols;
    logic [CNT_W-1:0] r_n1_cols;
    logic [CNT_W-1:0] w_n;
    logic             w_busy;
    logic             w_load;
    t_pack_ctl        w_ctl;
    t_load_stat       w_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_load      = i_in_valid && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_cols  <= CNT_W'(MAX_COLS);
            r_n1_cols <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_N_COLS:  r_n_cols  <= i_cfg_data[CNT_W-1:0];
                CFG_N1_COLS: r_n1_cols <= i_cfg_data[CNT_W-1:0];
                default:     r_n_cols  <= r_n_cols;
            endcase
        end
    end

    always_comb begin
        if (r_n_cols == '0) begin
            w_n = CNT_W'(1);
        end else if (r_n_cols > CNT_W'(MAX_COLS)) begin
            w_n = CNT_W'(MAX_COLS);
        end else begin
            w_n = r_n_cols;
        end
    end

    cpb_load u_load (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_req   (i_in_req),
        .i_n     (w_n),
        .i_n1    (r_n1_cols),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    cpb_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_load && i_in_req.last),
        .i_n         (w_n),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule

@@ rtl/cpb_ram.sv @@
module cpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cpb_load.sv @@
module cpb_load (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  cpb_pkg::t_in_req         i_req,
    input  logic [cpb_pkg::CNT_W-1:0] i_n,
    input  logic [cpb_pkg::CNT_W-1:0] i_n1,
    input  cpb_pkg::t_pack_ctl       i_ctl,
    output cpb_pkg::t_load_stat      o_stat
);
    import cpb_pkg::*;

    logic [MAX_COLS-1:0] r_mapped;
    logic [CNT_W-1:0]    r_next_pos;
    logic [CNT_W-1:0]    r_mf_count;
    logic [CNT_W:0]      w_mf_col;
    logic [COL_W-1:0]    w_map_col;
    logic                w_map;
    logic                w_mf_step;
    logic [COL_W-1:0]    w_ord_rdata;

    always_comb begin
        w_map     = 1'b0;
        w_map_col = i_req.column;
        w_mf_step = 1'b0;
        w_mf_col  = {1'b0, i_n1} + {1'b0, r_mf_count};
        case (i_req.operation)
            OP_SINGLETON: begin
                w_map_col = i_req.column;
                w_map = ({1'b0, i_req.column} < i_n1) && ({1'b0, i_req.column} < i_n)
                        && !r_mapped[i_req.column] && (r_next_pos < i_n);
            end
            OP_DEAD: begin
                w_map_col = w_mf_col[COL_W-1:0];
                if (r_mf_count < CNT_W'(MAX_COLS)) begin
                    w_mf_step = 1'b1;
                    w_map = (w_mf_col < {1'b0, i_n}) && !i_req.dead
                            && !r_mapped[w_mf_col[COL_W-1:0]] && (r_next_pos < i_n);
                end
            end
            default: begin
                w_map = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_mapped   <= '0;
            r_next_pos <= '0;
            r_mf_count <= '0;
        end else if (i_load) begin
            if (w_map) begin
                r_mapped[w_map_col] <= 1'b1;
                r_next_pos          <= r_next_pos + 1'b1;
            end
            if (w_mf_step) begin
                r_mf_count <= r_mf_count + 1'b1;
            end
        end
    end

    cpb_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_COLS)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (i_load && w_map),
        .i_waddr (r_next_pos[COL_W-1:0]),
        .i_wdata (w_map_col),
        .i_re    (i_ctl.ord_re),
        .i_raddr (i_ctl.ord_raddr),
        .o_rdata (w_ord_rdata)
    );

    always_comb begin
        o_stat.mapped    = r_mapped;
        o_stat.next_pos  = r_next_pos;
        o_stat.ord_rdata = w_ord_rdata;
    end

endmodule

@@ rtl/cpb_pack.sv @@
module cpb_pack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cpb_pkg::CNT_W-1:0] i_n,
    input  cpb_pkg::t_load_stat       i_stat,
    output cpb_pkg::t_pack_ctl        o_ctl,
    output logic                      o_busy,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cpb_pkg::t_out_res         o_out_res
);
    import cpb_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_rank;
    logic [CNT_W-1:0] r_p;
    logic             r_out_valid;
    t_out_res         r_out;

    logic             w_pos_we;
    logic [COL_W-1:0] w_pos_waddr;
    logic [COL_W-1:0] w_pos_wdata;
    logic             w_inv_we;
    logic [COL_W-1:0] w_inv_waddr;
    logic [COL_W-1:0] w_inv_wdata;
    logic             w_c_re;
    logic [COL_W-1:0] w_pos_rdata;
    logic [COL_W-1:0] w_inv_rdata;
    logic             w_a_take;
    logic             w_b_take;
    logic             w_out_acc;
    logic             w_last_col;

    assign w_a_take   = {1'b0, i_stat.ord_rdata} < i_n;
    assign w_b_take   = (r_idx != i_n) && !i_stat.mapped[r_idx[COL_W-1:0]];
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_last_col = (r_idx == i_n - 1'b1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_A_RD;
            S_A_RD:   n_state = (r_idx == i_stat.next_pos) ? S_B : S_A_WR;
            S_A_WR:   n_state = S_A_RD;
            S_B:      if (r_idx == i_n) n_state = S_C_RD;
            S_C_RD:   n_state = S_C_LD;
            S_C_LD:   n_state = S_C_WAIT;
            S_C_WAIT: if (w_out_acc) n_state = r_out.final_res ? S_IDLE : S_C_RD;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = (r_state != S_IDLE);
        o_ctl.clear   = 1'b0;
        o_ctl.ord_re  = 1'b0;
        o_ctl.ord_raddr = r_idx[COL_W-1:0];
        w_pos_we      = 1'b0;
        w_pos_waddr   = r_idx[COL_W-1:0];
        w_pos_wdata   = r_p[COL_W-1:0];
        w_inv_we      = 1'b0;
        w_inv_waddr   = r_p[COL_W-1:0];
        w_inv_wdata   = r_idx[COL_W-1:0];
        w_c_re        = 1'b0;
        case (r_state)
            S_A_RD: begin
                o_ctl.ord_re = (r_idx != i_stat.next_pos);
            end
            S_A_WR: begin
                w_pos_we    = w_a_take;
                w_pos_waddr = i_stat.ord_rdata;
                w_pos_wdata = r_rank[COL_W-1:0];
                w_inv_we    = w_a_take;
                w_inv_waddr = r_rank[COL_W-1:0];
                w_inv_wdata = i_stat.ord_rdata;
            end
            S_B: begin
                w_pos_we = w_b_take;
                w_inv_we = w_b_take;
            end
            S_C_RD: begin
                w_c_re = 1'b1;
            end
            S_C_WAIT: begin
                o_ctl.clear = w_out_acc && r_out.final_res;
            end
            default: begin
                o_busy = (r_state != S_IDLE);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_C_LD) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx  <= '0;
                r_rank <= '0;
            end
            S_A_RD: begin
                if (r_idx == i_stat.next_pos) begin
                    r_idx <= '0;
                    r_p   <= r_rank;
                end
            end
            S_A_WR: begin
                r_idx <= r_idx + 1'b1;
                if (w_a_take) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            S_B: begin
                if (r_idx == i_n) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (w_b_take) begin
                        r_p <= r_p + 1'b1;
                    end
                end
            end
            S_C_LD: begin
                r_out.out_column <= r_idx[COL_W-1:0];
                r_out.position   <= w_pos_rdata;
                r_out.inverse    <= w_inv_rdata;
                r_out.live       <= ({1'b0, w_pos_rdata} < r_rank);
                r_out.rank       <= r_rank;
                r_out.final_res  <= w_last_col;
            end
            S_C_WAIT: begin
                if (w_out_acc) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    cpb_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_COLS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_pos_we),
        .i_waddr (w_pos_waddr),
        .i_wdata (w_pos_wdata),
        .i_re    (w_c_re),
        .i_raddr (r_idx[COL_W-1:0]),
        .o_rdata (w_pos_rdata)
    );

    cpb_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_COLS)
    ) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (w_inv_we),
        .i_waddr (w_inv_waddr),
        .i_wdata (w_inv_wdata),
        .i_re    (w_c_re),
        .i_raddr (r_idx[COL_W-1:0]),
        .o_rdata (w_inv_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

@@ verif/tb_column_permutation_builder_top.sv @@
`timescale 1ns / 1ps

module tb_column_permutation_builder_top;

    import cpb_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS  = 250;
    localparam logic [6:0]  EMPTY_SLOT    = 7'h7F;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_req            i_in_req;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_res           o_out_res;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;

    // predictor state
    logic [6:0]         fwd_slot [MAX_COLS];
    logic [COL_W-1:0]   inv_col [MAX_COLS];
    logic               dead_seen [MAX_COLS];
    int unsigned        next_slot;
    int unsigned        mf_count;
    int unsigned        reg_n_cols;
    int unsigned        reg_n1_cols;

    t_out_res           expected_columns [$];
    int unsigned        mismatch_count;
    int unsigned        requests_sent;
    int unsigned        builds_done;
    int unsigned        columns_checked;
    bit                 steady;

    column_permutation_builder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_column_permutation_builder_top: FAIL");
        $finish;
    end

    function automatic int unsigned active_cols();
        int unsigned v;
        v = reg_n_cols;
        if (v < 1) v = 1;
        if (v > MAX_COLS) v = MAX_COLS;
        return v;
    endfunction

    function automatic void clear_build_state();
        for (int j = 0; j < MAX_COLS; j++) begin
            fwd_slot[j]  = EMPTY_SLOT;
            dead_seen[j] = 1'b0;
        end
        next_slot = 0;
        mf_count  = 0;
    endfunction

    function automatic void map_column(int unsigned c, int unsigned n);
        if (c < n && fwd_slot[c] == EMPTY_SLOT && next_slot < n) begin
            fwd_slot[c] = next_slot[6:0];
            next_slot++;
        end
    endfunction

    // Update the load state and, on the last request, queue one result per column.
    function automatic void apply_request(t_in_req r);
        int unsigned n;
        int unsigned j;
        int unsigned rank;
        int unsigned p;
        int unsigned c;
        int unsigned pos [MAX_COLS];
        t_out_res    res;
        n = active_cols();
        if (r.operation == OP_SINGLETON) begin
            if (r.column < reg_n1_cols) map_column(r.column, n);
        end else if (mf_count < MAX_COLS) begin
            j = reg_n1_cols + mf_count;
            if (j < n) begin
                dead_seen[j] = r.dead;
                if (!r.dead) map_column(j, n);
            end
            mf_count++;
        end
        if (!r.last) return;

        rank = 0;
        for (j = 0; j < n; j++) begin
            if (fwd_slot[j] != EMPTY_SLOT) begin
                c = 0;
                for (int k = 0; k < n; k++) begin
                    if (fwd_slot[k] != EMPTY_SLOT && fwd_slot[k] < fwd_slot[j]) c++;
                end
                pos[j] = c;
                rank++;
            end
        end
        p = rank;
        for (j = 0; j < n; j++) begin
            if (fwd_slot[j] == EMPTY_SLOT) begin
                pos[j] = p;
                p++;
            end
        end
        for (j = 0; j < n; j++) inv_col[pos[j] % MAX_COLS] = j[COL_W-1:0];
        for (j = 0; j < n; j++) begin
            res.out_column = j[COL_W-1:0];
            res.position   = pos[j][COL_W-1:0];
            res.inverse    = inv_col[j];
            res.live       = pos[j] < rank;
            res.rank       = rank[CNT_W-1:0];
            res.final_res  = (j == n - 1);
            expected_columns.push_back(res);
        end
        builds_done++;
        clear_build_state();
    endfunction

    function automatic void check_column_result(t_out_res got);
        t_out_res want;
        if (expected_columns.size() == 0) begin
            $error("unexpected result for column %0d", got.out_column);
            mismatch_count++;
            return;
        end
        want = expected_columns.pop_front();
        columns_checked++;
        if (got.out_column !== want.out_column) begin
            $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
            mismatch_count++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatch_count++;
        end
        if (got.inverse !== want.inverse) begin
            $error("inverse: expected %0d, got %0d", want.inverse, got.inverse);
            mismatch_count++;
        end
        if (got.live !== want.live) begin
            $error("live: expected %0d, got %0d", want.live, got.live);
            mismatch_count++;
        end
        if (got.rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, got.rank);
            mismatch_count++;
        end
        if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_column_result(o_out_res);
        i_out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 35);
    end

    task automatic send_req(logic op, logic [COL_W-1:0] col, logic dead, logic last);
        t_in_req r;
        r.operation = op;
        r.column    = col;
        r.dead      = dead;
        r.last      = last;
        if (!steady) begin
            while ($urandom_range(0, 99) < 35) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        apply_request(r);
        requests_sent++;
    endtask

    // drop valid, wait for all outstanding results, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned n, int unsigned n1);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_N_COLS;
        i_cfg_data  <= n[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_n_cols = n % 128;
        i_cfg_index <= CFG_N1_COLS;
        i_cfg_data  <= n1[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_n1_cols = n1 % 128;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_registers();
        send_req(OP_SINGLETON, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b1, 1'b0);
        send_req(OP_DEAD, 6'd63, 1'b0, 1'b1);
    endtask

    task automatic test_singleton_rules();
        wait_drained();
        set_config(8, 5);
        send_req(OP_SINGLETON, 6'd3, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd0, 1'b1, 1'b0);
        send_req(OP_SINGLETON, 6'd3, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd6, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd4, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b1, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        set_config(0, 127);
        send_req(OP_SINGLETON, 6'd63, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd0, 1'b0, 1'b1);
        wait_drained();
        set_config(127, 64);
        send_req(OP_SINGLETON, 6'd63, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b1);
        wait_drained();
        set_config(1, 0);
        send_req(OP_DEAD, 6'd0, 1'b1, 1'b1);
    endtask

    task automatic test_reconfig_during_load();
        wait_drained();
        set_config(16, 8);
        send_req(OP_SINGLETON, 6'd7, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd2, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd5, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd1, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd6, 1'b0, 1'b0);
        wait_drained();
        set_config(3, 8);
        send_req(OP_SINGLETON, 6'd0, 1'b0, 1'b0);
        send_req(OP_DEAD, 6'd0, 1'b0, 1'b0);
        send_req(OP_SINGLETON, 6'd2, 1'b0, 1'b1);
    endtask

    task automatic test_random_builds();
        int unsigned first_count;
        int unsigned run;
        int unsigned n;
        int unsigned n1;
        int unsigned n_eff;
        int unsigned n1_eff;
        int unsigned take;
        int unsigned deads;
        int unsigned total;
        int unsigned k;
        int unsigned tmp;
        int unsigned sel;
        int unsigned order [MAX_COLS];
        logic [COL_W-1:0] col;
        first_count = requests_sent;
        run = 0;
        while (requests_sent - first_count < RANDOM_ITEMS) begin
            wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 75) n = $urandom_range(1, 12);
            else if (sel < 90) n = $urandom_range(13, 64);
            else n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(64, 127);
            n_eff = (n < 1) ? 1 : ((n > MAX_COLS) ? MAX_COLS : n);
            sel = $urandom_range(0, 99);
            if (sel < 50) n1 = $urandom_range(0, n_eff);
            else if (sel < 70) n1 = 0;
            else if (sel < 90) n1 = n_eff;
            else n1 = $urandom_range(0, 127);
            if (run == 1) begin
                n  = $urandom_range(1, 8);
                n1 = 0;
            end
            set_config(n, n1);
            n_eff  = active_cols();
            n1_eff = (reg_n1_cols < n_eff) ? reg_n1_cols : n_eff;
            steady = (run >= 4 && run < 8);
            if (run == 1) begin
                // overrun the dead-flag counter past its saturation point
                for (k = 0; k < MAX_COLS + 4; k++) begin
                    send_req(OP_DEAD, 6'($urandom), ($urandom_range(0, 99) < 25),
                             k == MAX_COLS + 3);
                end
            end else if ($urandom_range(0, 99) < 75) begin
                for (k = 0; k < n1_eff; k++) order[k] = k;
                for (k = n1_eff; k > 1; k--) begin
                    sel = $urandom_range(0, k - 1);
                    tmp = order[k - 1];
                    order[k - 1] = order[sel];
                    order[sel] = tmp;
                end
                take  = n1_eff - $urandom_range(0, n1_eff / 3);
                deads = n_eff - n1_eff;
                total = take + deads;
                if (total == 0) begin
                    send_req(1'($urandom), 6'($urandom), 1'($urandom), 1'b1);
                end
                for (k = 0; k < take; k++) begin
                    send_req(OP_SINGLETON, order[k][COL_W-1:0], 1'($urandom),
                             k == total - 1);
                end
                for (k = 0; k < deads; k++) begin
                    send_req(OP_DEAD, 6'($urandom), ($urandom_range(0, 99) < 25),
                             take + k == total - 1);
                end
            end else begin
                total = $urandom_range(1, 20);
                for (k = 0; k < total; k++) begin
                    if ($urandom_range(0, 1) == 0) col = 6'($urandom);
                    else col = 6'($urandom_range(0, n_eff - 1));
                    send_req(1'($urandom), col, 1'($urandom), k == total - 1);
                end
            end
            run++;
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_req       <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_N_COLS;
        i_cfg_data     <= '0;
        steady          = 1'b0;
        mismatch_count  = 0;
        requests_sent   = 0;
        builds_done     = 0;
        columns_checked = 0;
        for (int j = 0; j < MAX_COLS; j++) inv_col[j] = '0;
        clear_build_state();
        reg_n_cols  = MAX_COLS;
        reg_n1_cols = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_registers();
        test_singleton_rules();
        test_register_extremes();
        test_reconfig_during_load();
        test_random_builds();
        wait_drained();

        $display("Ran %0d permutation builds from %0d requests,", builds_done,
                 requests_sent);
        $display("checked %0d column results across register extremes and reloads.",
                 columns_checked);
        if (mismatch_count == 0) begin
            $display("tb_column_permutation_builder_top: PASS");
        end else begin
            $display("tb_column_permutation_builder_top: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpb_pkg.sv
rtl/cpb_ram.sv
rtl/cpb_load.sv
rtl/cpb_pack.sv
rtl/column_permutation_builder_top.sv
verif/tb_column_permutation_builder_top.sv
